@@ src/dmat_pkg.sv @@
// ----------------------------------------------------------------------------
// dmat_pkg: shared types and constants for the matrix determinant block
// Field widths, sequencer states, datapath control and the permutation table
// used to walk the terms of the determinant.
// ----------------------------------------------------------------------------
package dmat_pkg;

  localparam int ELEM_W  = 12;  // matrix element width
  localparam int DET_W   = 50;  // determinant width
  localparam int DIM_W   = 3;   // dimension register width
  localparam int PART_W  = 36;  // partial product of up to three elements
  localparam int PROD_W  = 48;  // product of four elements
  localparam int TBL_DIM = 4;   // size the permutation table is built for
  localparam int ROW_W   = 2;   // row / column index into the table
  localparam int PERM_W  = 5;   // index over the 24 permutations

  localparam logic [PERM_W-1:0] PERM_LAST = PERM_W'(23);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [PERM_W-1:0]        perm_idx_t;
  typedef logic [ROW_W-1:0]         row_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } dmat_state_t;

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;     // clear accumulator
    logic load;    // first factor of a term
    logic mul;     // multiply running product by next factor
    logic acc;     // add finished term to accumulator
    logic neg;     // term has odd permutation sign
    logic out_ld;  // capture determinant into output register
  } dmat_mac_ctl_t;

  // column chosen for each row, row 0 in bits [1:0]; lexicographic order
  function automatic logic [2*TBL_DIM-1:0] perm_cols(perm_idx_t idx);
    logic [2*TBL_DIM-1:0] cols;
    unique case (idx)
      5'd0:    cols = 8'hE4;
      5'd1:    cols = 8'hB4;
      5'd2:    cols = 8'hD8;
      5'd3:    cols = 8'h78;
      5'd4:    cols = 8'h9C;
      5'd5:    cols = 8'h6C;
      5'd6:    cols = 8'hE1;
      5'd7:    cols = 8'hB1;
      5'd8:    cols = 8'hC9;
      5'd9:    cols = 8'h39;
      5'd10:   cols = 8'h8D;
      5'd11:   cols = 8'h2D;
      5'd12:   cols = 8'hD2;
      5'd13:   cols = 8'h72;
      5'd14:   cols = 8'hC6;
      5'd15:   cols = 8'h36;
      5'd16:   cols = 8'h4E;
      5'd17:   cols = 8'h1E;
      5'd18:   cols = 8'h93;
      5'd19:   cols = 8'h63;
      5'd20:   cols = 8'h87;
      5'd21:   cols = 8'h27;
      5'd22:   cols = 8'h4B;
      5'd23:   cols = 8'h1B;
      default: cols = 8'hE4;
    endcase
    return cols;
  endfunction

  // lexicographic permutation parity runs even, odd, odd, even
  function automatic logic perm_odd(perm_idx_t idx);
    return idx[0] ^ idx[1];
  endfunction

endpackage

@@ src/dmat_if.sv @@
// ----------------------------------------------------------------------------
// dmat_if: valid/ready channels of the matrix determinant block
// Element input, determinant output and dimension configuration.
// ----------------------------------------------------------------------------
interface dmat_in_if import dmat_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface dmat_out_if import dmat_pkg::*; ();
  logic valid;
  logic ready;
  det_t determinant;

  modport source (output valid, output determinant, input ready);
  modport sink   (input valid, input determinant, output ready);
endinterface

interface dmat_cfg_if import dmat_pkg::*; ();
  logic valid;
  logic ready;
  dim_t dimension;

  modport source (output valid, output dimension, input ready);
  modport sink   (input valid, input dimension, output ready);
endinterface

@@ src/dmat_store.sv @@
// ----------------------------------------------------------------------------
// dmat_store: matrix element memory
// One write port for loading, one read port with registered data.
// ----------------------------------------------------------------------------
module dmat_store import dmat_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  elem_t             wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output elem_t             rd_data
);

  elem_t mem [DEPTH];
  elem_t rd_data_r;

  // write on load beats
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/dmat_mac.sv @@
// ----------------------------------------------------------------------------
// dmat_mac: shared multiply-accumulate unit
// Builds each permutation term one factor per cycle and sums signed terms.
// ----------------------------------------------------------------------------
module dmat_mac import dmat_pkg::*; (
  input  logic          clk,
  input  dmat_mac_ctl_t ctl,
  input  elem_t         rd_data,
  output det_t          determinant
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] mul_res;
  logic signed [PART_W-1:0] part;
  det_t                     prod_ext;
  det_t                     addend;
  det_t                     acc_r;
  det_t                     out_r;

  // running product times next factor
  assign part    = $signed(prod_r[PART_W-1:0]);
  assign mul_res = part * rd_data;

  // signed term to add
  assign prod_ext = {{(DET_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign addend   = ctl.neg ? -prod_ext : prod_ext;

  // product register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= {{(PROD_W-ELEM_W){rd_data[ELEM_W-1]}}, rd_data};
    end else if (ctl.mul) begin
      prod_r <= mul_res;
    end
  end

  // accumulator and output register
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= acc_r + addend;
    end
    if (ctl.out_ld) begin
      out_r <= acc_r;
    end
  end

  assign determinant = out_r;

endmodule

@@ src/dmat_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmat_ctrl: load counter and term sequencer
// Loads elements row-major, then walks every permutation term, fetching one
// factor per cycle and steering the multiply-accumulate unit.
// ----------------------------------------------------------------------------
module dmat_ctrl import dmat_pkg::*; #(
  parameter int MAX_DIM = 4,
  parameter int ADDR_W  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_valid,
  input  dim_t              cfg_dimension,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] rd_addr,
  output dmat_mac_ctl_t     mac_ctl
);

  localparam int TOT_W = $clog2(MAX_DIM * MAX_DIM + 1);

  dmat_state_t          state_r, state_nxt;
  dim_t                 n_r;
  logic [ADDR_W-1:0]    count_r;
  perm_idx_t            perm_r;
  row_t                 row_r;
  logic [ADDR_W-1:0]    base_r;
  logic                 out_valid_r;

  logic [2*DIM_W-1:0]   n_sq;
  logic [TOT_W-1:0]     total;
  logic [TOT_W-1:0]     cnt_inc;
  logic                 last_elem;
  logic                 in_acc;
  logic                 out_acc;
  logic [2*TBL_DIM-1:0] cols;
  logic                 perm_ok;
  logic                 last_row;
  row_t                 next_row;

  // clamp a written dimension to 1..MAX_DIM
  function automatic dim_t clamp_dim(dim_t d);
    dim_t r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // element count bookkeeping
  assign n_sq      = {{DIM_W{1'b0}}, n_r} * {{DIM_W{1'b0}}, n_r};
  assign total     = n_sq[TOT_W-1:0];
  assign cnt_inc   = TOT_W'(count_r) + TOT_W'(1);
  assign last_elem = (cnt_inc == total);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;

  // a table term counts only if rows past the dimension stay on the diagonal
  assign cols = perm_cols(perm_r);
  always_comb begin
    perm_ok = 1'b1;
    for (int r = 0; r < TBL_DIM; r++) begin
      if ((DIM_W'(r) >= n_r) && (cols[2*r +: 2] != ROW_W'(r))) begin
        perm_ok = 1'b0;
      end
    end
  end

  assign last_row = ((DIM_W'(row_r) + DIM_W'(1)) == n_r);
  assign next_row = row_r + ROW_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && last_elem) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (perm_ok) begin
          state_nxt = ST_MUL;
        end else if (perm_r == PERM_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        if (last_row) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = (perm_r == PERM_LAST) ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    rd_addr        = ADDR_W'(cols[1:0]);
    mac_ctl        = '0;
    mac_ctl.neg    = perm_odd(perm_r);
    unique case (state_r)
      ST_LOAD: begin
        in_ready    = !cfg_valid;
        mac_ctl.clr = in_valid && !cfg_valid && last_elem;
      end
      ST_SCAN: begin
        rd_addr = ADDR_W'(cols[1:0]);
      end
      ST_MUL: begin
        rd_addr      = base_r + ADDR_W'(cols[2*next_row +: 2]);
        mac_ctl.load = (row_r == '0);
        mac_ctl.mul  = (row_r != '0);
      end
      ST_ACC: begin
        mac_ctl.acc = 1'b1;
      end
      ST_DONE: begin
        mac_ctl.out_ld = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign wr_en     = in_acc;
  assign wr_addr   = count_r;
  assign out_valid = out_valid_r;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      n_r         <= DIM_W'(MAX_DIM);
      count_r     <= '0;
      perm_r      <= '0;
      row_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // dimension write restarts loading
      if (cfg_valid) begin
        n_r     <= clamp_dim(cfg_dimension);
        count_r <= '0;
      end else if (in_acc) begin
        count_r <= last_elem ? '0 : count_r + ADDR_W'(1);
      end

      // term walk
      unique case (state_r)
        ST_LOAD: begin
          perm_r <= '0;
        end
        ST_SCAN: begin
          row_r  <= '0;
          base_r <= ADDR_W'(n_r);
          if (!perm_ok) begin
            perm_r <= perm_r + PERM_W'(1);
          end
        end
        ST_MUL: begin
          row_r  <= next_row;
          base_r <= base_r + ADDR_W'(n_r);
        end
        ST_ACC: begin
          perm_r <= perm_r + PERM_W'(1);
        end
        ST_DONE: begin
          perm_r <= '0;
        end
        default: begin
          perm_r <= '0;
        end
      endcase

      // result beat pending
      if (mac_ctl.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // load position stays inside the current matrix
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (TOT_W'(count_r) < total))
    else $error("load count beyond matrix size");

  // term index never runs past the table while terms are walked
  a_perm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_MUL || state_r == ST_ACC) |->
      (perm_r <= PERM_LAST))
    else $error("permutation index out of range");

  // last factor of a term is always followed by its accumulation
  a_mul_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && last_row) |=> (state_r == ST_ACC))
    else $error("term not accumulated after last factor");

  // output register only reloaded when the previous result is gone
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctl.out_ld |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");
`endif

endmodule

@@ src/matrix_determinant.sv @@
// ----------------------------------------------------------------------------
// matrix_determinant: exact determinant of a square integer matrix
// Loads elements row-major and sums all signed permutation terms with one
// shared multiplier.
// ----------------------------------------------------------------------------
// Elements of an n x n matrix (n from the dimension register, clamped to
// 1..MAX_DIM) are taken one beat per cycle in row-major order while no
// dimension write is offered. After the last element the block stops taking
// input and walks the 24 entries of a permutation table, checking each
// entry; each of the n! entries that belong to an n x n matrix then has its
// first factor loaded, each further factor multiplied in through the single
// 36x12 multiplier, and its term added. The determinant then sits in an
// output register while the next matrix loads. A write of the dimension
// restarts loading at row 0.
module matrix_determinant import dmat_pkg::*; #(
  parameter int MAX_DIM = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  dmat_in_if.sink           in_ch,
  dmat_out_if.source        out_ch,
  dmat_cfg_if.sink          cfg_ch
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  elem_t             rd_data;
  dmat_mac_ctl_t     mac_ctl;

  // configuration is always taken
  assign cfg_ch.ready = 1'b1;

  // sequencer
  dmat_ctrl #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .cfg_valid     (cfg_ch.valid),
    .cfg_dimension (cfg_ch.dimension),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .mac_ctl       (mac_ctl)
  );

  // element memory
  dmat_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.element),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // multiply-accumulate
  dmat_mac u_mac (
    .clk         (clk),
    .ctl         (mac_ctl),
    .rd_data     (rd_data),
    .determinant (out_ch.determinant)
  );

endmodule

@@ sim/matrix_determinant_tb.sv @@
// ----------------------------------------------------------------------------
// matrix_determinant_tb: self-checking bench for the matrix determinant block
// Streams square matrices of 12-bit elements under every dimension setting,
// predicts each determinant by cofactor expansion along the first row and
// checks every output beat against it, with random gaps and stalls.
// ----------------------------------------------------------------------------
module matrix_determinant_tb import dmat_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM    = 4;
  localparam int LAT_CYCLES = 200;   // longer than one full 4x4 computation
  localparam int LONG_HOLD  = 600;   // long output back-pressure stretch
  localparam int IDLE_LIMIT = 4000;  // watchdog: cycles with no beat at all
  localparam int RAND_ITEMS = 700;

  logic clk = 1'b0;
  logic rst_n;

  dmat_in_if  in_ch ();
  dmat_out_if out_ch ();
  dmat_cfg_if cfg_ch ();

  matrix_determinant #(.MAX_DIM(MAX_DIM)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the block
  elem_t mat_store [16];
  int    load_pos = 0;
  dim_t  cur_dim  = dim_t'(4);

  elem_t elem_feed_q [$];   // elements waiting to be offered
  det_t  det_due_q   [$];   // determinants still to come out

  int err_cnt      = 0;
  int in_idle_max  = 5;
  int out_idle_max = 5;
  int hold_req     = 0;
  int hold_ack     = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int idle_cycles  = 0;
  int draw;

  function automatic int eff_size(dim_t d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  // cofactor expansion of the minor on rows row..n-1 and the columns in cols
  function automatic longint cofactor_sum(int n, int row, logic [3:0] cols);
    longint sum;
    longint sgn;
    longint e;
    sum = 0;
    sgn = 1;
    for (int c = 0; c < n; c++) begin
      if (cols[c]) begin
        e = longint'(mat_store[row * n + c]);
        if (row == n - 1) return e;
        sum += sgn * e * cofactor_sum(n, row + 1, cols & ~(4'b0001 << c));
        sgn = -sgn;
      end
    end
    return sum;
  endfunction

  // store one accepted element, queue the determinant when the matrix is full
  task automatic take_element(elem_t e);
    int n;
    n = eff_size(cur_dim);
    mat_store[load_pos] = e;
    load_pos++;
    if (load_pos >= n * n) begin
      load_pos = 0;
      det_due_q.push_back(det_t'(cofactor_sum(n, 0, 4'((1 << n) - 1))));
    end
  endtask

  task automatic check_determinant(det_t got);
    det_t want;
    if (det_due_q.size() == 0) begin
      $display("%0t: unexpected determinant beat, expected none, got %0d", $time, got);
      err_cnt++;
    end else begin
      want = det_due_q.pop_front();
      if (got !== want) begin
        $display("%0t: determinant mismatch, expected %0d, got %0d", $time, want, got);
        err_cnt++;
      end
    end
  endtask

  // input driver: one beat per queued element, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) take_element(in_ch.element);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (elem_feed_q.size() > 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.element <= elem_feed_q.pop_front();
          gap_left      <= $urandom_range(0, in_idle_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each beat, random stall after each, long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_determinant(out_ch.determinant);
      if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        stall_left   <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        draw = $urandom_range(0, out_idle_max);
        if (draw == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left   <= draw - 1;
        end
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** matrix_determinant: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // write the dimension register; the block must be idle
  task automatic set_dimension(dim_t d);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.dimension <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_dim  = d;
    load_pos = 0;
    @(negedge clk);
  endtask

  // wait until every element is taken and every determinant has come out
  task automatic drain();
    do @(negedge clk);
    while (elem_feed_q.size() != 0 || in_ch.valid || det_due_q.size() != 0);
    repeat (LAT_CYCLES) @(negedge clk);
  endtask

  function automatic elem_t pick_element(int style);
    case (style)
      0:       return elem_t'($urandom_range(0, 4095));
      1:       return $urandom_range(0, 1) ? elem_t'(-2048) : elem_t'(2047);
      default: return elem_t'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  task automatic push_elements(int count);
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < count; i++) elem_feed_q.push_back(pick_element(style));
  endtask

  // stimulus
  initial begin
    dim_t sweep [8];
    dim_t d;
    int   n;
    int   mats;
    int   part;
    int   phase;
    int   items_made;

    sweep            = '{3'd3, 3'd7, 3'd5, 3'd6, 3'd4, 3'd2, 3'd1, 3'd0};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.element    = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.dimension = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset dimension of 4: Hadamard pattern of extreme elements
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        elem_feed_q.push_back(($countones(r & c) % 2) ? elem_t'(-2048) : elem_t'(2047));
    drain();

    // 1x1 matrices give the element itself
    set_dimension(dim_t'(1));
    elem_feed_q.push_back(elem_t'(2047));
    elem_feed_q.push_back(elem_t'(-2048));
    drain();

    // dimension zero acts as one
    set_dimension(dim_t'(0));
    elem_feed_q.push_back(elem_t'(-1));
    drain();

    // partial matrix abandoned by a dimension write
    set_dimension(dim_t'(2));
    elem_feed_q.push_back(elem_t'(5));
    elem_feed_q.push_back(elem_t'(-6));
    elem_feed_q.push_back(elem_t'(7));
    drain();

    // random phases: every dimension code first, then random ones
    items_made = 0;
    phase      = 0;
    while (items_made < RAND_ITEMS) begin
      if (phase < 8) d = sweep[phase];
      else d = dim_t'($urandom_range(0, 7));
      n = eff_size(d);
      in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 5;
      out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      set_dimension(d);
      mats = $urandom_range(1, 4);
      // long output hold so the block fills up and stalls its input
      if (phase == 1) begin
        hold_req++;
        mats = 4;
      end
      for (int m = 0; m < mats; m++) push_elements(n * n);
      items_made += mats * n * n;
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        part = $urandom_range(1, n * n - 1);
        push_elements(part);
        items_made += part;
      end
      drain();
      phase++;
    end

    if (err_cnt == 0) begin
      $display("** matrix_determinant: PASSED **");
    end else begin
      $display("** matrix_determinant: FAILED **");
    end
    $finish;
  end

endmodule
